>>> rtl/core/assert_macros.svh
// Assertion macros shared by the deque RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg)
`endif
`endif

>>> rtl/core/adeq_pkg.sv
// Package: sizes, operation and status codes, and controller commands for the deque.
package adeq_pkg;

  // Storage geometry
  localparam int DEPTH     = 8;
  localparam int WORD_BITS = 32;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Port field widths
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Operation codes
  localparam logic [KIND_W-1:0] OP_INS_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] OP_INS_REAR  = 2'd1;
  localparam logic [KIND_W-1:0] OP_REM_FRONT = 2'd2;
  localparam logic [KIND_W-1:0] OP_REM_REAR  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNDER   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming operation
    logic exec;     // perform the operation, register the result
  } adeq_cmd_t;

endpackage

>>> rtl/core/adeq_ctrl.sv
// Controller: sequences capture, execute and result strobe for each operation.
`include "assert_macros.svh"

module adeq_ctrl
  import adeq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output adeq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_RESP;
      S_RESP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs and commands
  assign busy        = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_RESP);
  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.exec    = (state_r == S_EXEC);

  `ASSERT_CLK(a_accept_busy, clk, rst_n, start && !busy |=> busy && !out_valid,
              "accepted transfer did not raise busy")
  `ASSERT_CLK(a_strobe_single, clk, rst_n, out_valid |=> !out_valid,
              "result strobe longer than one cycle")
  `ASSERT_CLK(a_exec_then_resp, clk, rst_n, cmd.exec |=> out_valid,
              "execute not followed by result strobe")

endmodule

>>> rtl/core/adeq_dp.sv
// Datapath: slot memory, front/end pointers and result registers.
`include "assert_macros.svh"

module adeq_dp
  import adeq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  adeq_cmd_t         cmd,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [DATA_W-1:0] in_entry_value,
  output logic [STAT_W-1:0] out_status,
  output logic [DATA_W-1:0] out_removed_value
);

  // Captured operation
  logic [KIND_W-1:0] kind_r;
  word_t             word_r;

  // Pointers: live slots are front_r .. end_r-1
  ptr_t front_r, front_nxt;
  cnt_t end_r, end_nxt;

  // Slot memory and registered read port
  word_t mem [DEPTH];
  word_t rd_data_r;
  logic  rd_ok_r;
  logic [STAT_W-1:0] status_r;

  logic              wr_en;
  ptr_t              wr_addr;
  ptr_t              rd_addr;
  logic              rd_ok;
  logic [STAT_W-1:0] status;
  logic              empty;
  cnt_t              front_ext;
  cnt_t              front_inc;
  cnt_t              end_dec;

  assign front_ext = {1'b0, front_r};
  assign front_inc = front_ext + 1'b1;
  assign end_dec   = end_r - 1'b1;
  assign empty     = (front_ext >= end_r);

  // Operation decode against current pointers
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = front_r;
    rd_addr   = front_r;
    rd_ok     = 1'b0;
    status    = ST_OK;
    front_nxt = front_r;
    end_nxt   = end_r;
    unique case (kind_r)
      OP_INS_FRONT: begin
        if (front_r != '0) begin
          wr_en     = 1'b1;
          wr_addr   = front_r - 1'b1;
          front_nxt = front_r - 1'b1;
        end else if (end_r == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          end_nxt = cnt_t'(1);
        end else begin
          status = ST_REFUSED;
        end
      end
      OP_INS_REAR: begin
        if (end_r == cnt_t'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = end_r[PTR_W-1:0];
          end_nxt = end_r + 1'b1;
        end
      end
      OP_REM_FRONT: begin
        if (empty) begin
          status = ST_UNDER;
        end else begin
          rd_ok   = 1'b1;
          rd_addr = front_r;
          // last entry taken: both positions go home
          if (front_inc >= end_r) begin
            front_nxt = '0;
            end_nxt   = '0;
          end else begin
            front_nxt = front_inc[PTR_W-1:0];
          end
        end
      end
      OP_REM_REAR: begin
        if (empty) begin
          status = ST_UNDER;
        end else begin
          rd_ok   = 1'b1;
          rd_addr = end_dec[PTR_W-1:0];
          if (front_ext >= end_dec) begin
            front_nxt = '0;
            end_nxt   = '0;
          end else begin
            end_nxt = end_dec;
          end
        end
      end
      default: status = ST_OK;
    endcase
  end

  // Capture and result registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      word_r <= word_t'(in_entry_value);
    end
    if (cmd.exec) begin
      status_r <= status;
    end
  end

  // Removal flag: cleared by reset so no stale word shows before the first result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
    end else if (cmd.exec) begin
      rd_ok_r <= rd_ok;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= word_r;
    end
    if (cmd.exec) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      end_r   <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      end_r   <= end_nxt;
    end
  end

  assign out_status        = status_r;
  assign out_removed_value = rd_ok_r ? DATA_W'(rd_data_r) : '0;

  `ASSERT_NEVER(a_end_range, clk, rst_n, end_r > cnt_t'(DEPTH),
                "end position beyond storage")
  `ASSERT_CLK(a_ptr_order, clk, rst_n,
              (front_r == '0 && end_r == '0) || (front_ext < end_r),
              "empty deque with pointers not at home")
  `ASSERT_CLK(a_rear_insert, clk, rst_n,
              cmd.exec && kind_r == OP_INS_REAR && end_r != cnt_t'(DEPTH)
              |=> end_r == cnt_t'($past(end_r) + 1'b1),
              "rear insert did not advance end position")
  `ASSERT_NEVER(a_removed_ok, clk, rst_n, rd_ok_r && status_r != ST_OK,
                "removed word flagged on a failed operation")

endmodule

>>> rtl/core/array_double_ended_queue.sv
// Top level: array-based double-ended queue, controller plus datapath.
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ---------------------------
//  input    in_kind, in_entry_value                 transfer on start && !busy
//  result   out_status, out_removed_value           transfer on out_valid
//
// Each operation passes through capture, execute (one memory write or one
// registered memory read plus pointer update) and result strobe; busy is high
// in execute and result strobe, so one operation must finish before the next.
// rst_n is synchronous, active low; it empties the deque (slot contents are
// not cleared). out_valid lasts one cycle and the receiver cannot stall it.
module array_double_ended_queue
  import adeq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [DATA_W-1:0] in_entry_value,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [DATA_W-1:0] out_removed_value
);

  adeq_cmd_t cmd;

  // Operation sequencing
  adeq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Storage and pointers
  adeq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_kind           (in_kind),
    .in_entry_value    (in_entry_value),
    .out_status        (out_status),
    .out_removed_value (out_removed_value)
  );

endmodule

>>> tb/sv/deque_checker.sv
`timescale 1ns / 100ps
// Deque checker: models the array deque from observed transfers and compares each result.
module deque_checker
  import adeq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [DATA_W-1:0] in_entry_value,
  input  logic              out_valid,
  input  logic [STAT_W-1:0] out_status,
  input  logic [DATA_W-1:0] out_removed_value,
  output int                error_count,
  output int                outstanding
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] removed;
  } deque_result_t;

  // Shadow copy of the deque: live words sit in head_idx .. tail_idx-1
  word_t         slots [DEPTH];
  int unsigned   head_idx = 0;
  int unsigned   tail_idx = 0;
  deque_result_t awaited [$];
  int            mismatches = 0;

  // Apply one operation to the shadow deque and return the result it must give
  function automatic deque_result_t apply_op(input logic [KIND_W-1:0] kind,
                                             input logic [DATA_W-1:0] value);
    deque_result_t r;
    word_t         w;
    r.status  = ST_OK;
    r.removed = '0;
    w         = word_t'(value);
    case (kind)
      OP_INS_FRONT: begin
        if (head_idx > 0 && head_idx < DEPTH) begin
          head_idx--;
          slots[head_idx] = w;
        end else if (head_idx == 0 && tail_idx == 0) begin
          // empty deque: word lands in slot zero
          slots[0] = w;
          tail_idx = 1;
        end else begin
          r.status = ST_REFUSED;
        end
      end
      OP_INS_REAR: begin
        if (tail_idx >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slots[tail_idx] = w;
          tail_idx++;
        end
      end
      OP_REM_FRONT: begin
        if (head_idx >= tail_idx) begin
          r.status = ST_UNDER;
        end else begin
          r.removed = slots[head_idx];
          head_idx++;
        end
      end
      OP_REM_REAR: begin
        if (head_idx >= tail_idx) begin
          r.status = ST_UNDER;
        end else begin
          tail_idx--;
          r.removed = slots[tail_idx];
        end
      end
    endcase
    // an emptied deque puts both positions back to zero
    if (head_idx >= tail_idx) begin
      head_idx = 0;
      tail_idx = 0;
    end
    return r;
  endfunction

  // Compare the result transfer first, then record any new operation
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (!rst_n) begin
      head_idx = 0;
      tail_idx = 0;
      awaited.delete();
    end else begin
      if (out_valid) begin
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing pending: status %0d removed %h",
                     $realtime, out_status, out_removed_value);
        end else begin
          exp_r = awaited.pop_front();
          if (out_status !== exp_r.status || out_removed_value !== exp_r.removed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected status %0d removed %h, got status %0d removed %h",
                       $realtime, exp_r.status, exp_r.removed, out_status,
                       out_removed_value);
          end
        end
      end
      if (start && !busy)
        awaited.push_back(apply_op(in_kind, in_entry_value));
    end
    error_count <= mismatches;
    outstanding <= awaited.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top: drives deque operations, watches for stalls and reports the verdict.
module tb;
  import adeq_pkg::*;

  localparam int WATCHDOG_LIMIT = 200;
  localparam int RANDOM_OPS     = 950;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  logic [KIND_W-1:0] in_kind        = OP_INS_FRONT;
  logic [DATA_W-1:0] in_entry_value = '0;
  logic              busy;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [DATA_W-1:0] out_removed_value;

  int error_count;
  int outstanding;
  int quiet_cycles = 0;
  bit idle_en      = 1'b1;

  always #2 clk = ~clk;

  array_double_ended_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_entry_value    (in_entry_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value)
  );

  deque_checker u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_entry_value    (in_entry_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .error_count       (error_count),
    .outstanding       (outstanding)
  );

  // Watchdog: any transfer on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One operation transfer, with an optional random gap ahead of it
  task automatic issue_op(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value);
    if (idle_en && $urandom_range(0, 99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start          <= 1'b1;
    in_kind        <= kind;
    in_entry_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off until every pending result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int                ins_bias;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    ins_bias = 50;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: underflow on empty, front insert into empty, refused front insert
    issue_op(OP_REM_FRONT, $urandom);
    issue_op(OP_REM_REAR, $urandom);
    issue_op(OP_INS_FRONT, '1);
    issue_op(OP_INS_FRONT, 32'h1234_5678);
    // fill to the last slot, then hit rear full
    issue_op(OP_INS_REAR, '0);
    issue_op(OP_INS_REAR, 32'hAAAA_AAAA);
    issue_op(OP_INS_REAR, 32'h5555_5555);
    issue_op(OP_INS_REAR, 32'h8000_0001);
    issue_op(OP_INS_REAR, 32'h7FFF_FFFE);
    issue_op(OP_INS_REAR, '1);
    issue_op(OP_INS_REAR, 32'hDEAD_BEEF);
    issue_op(OP_INS_REAR, $urandom);
    // front opens up: rear still full, front insert refills slot zero
    issue_op(OP_REM_FRONT, $urandom);
    issue_op(OP_INS_REAR, $urandom);
    issue_op(OP_INS_FRONT, 32'h0F0F_F0F0);
    // empty it from both ends, then underflow again
    repeat (4) issue_op(OP_REM_FRONT, $urandom);
    repeat (4) issue_op(OP_REM_REAR, $urandom);
    issue_op(OP_REM_REAR, $urandom);
    drain();

    // Random walk with a drifting insert/remove balance
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 60 == 0)
        ins_bias = $urandom_range(25, 75);
      idle_en = !(n >= 400 && n < 600);
      if (n == 500)
        drain();
      if ($urandom_range(0, 99) < ins_bias)
        kind = $urandom_range(0, 1) ? OP_INS_REAR : OP_INS_FRONT;
      else
        kind = $urandom_range(0, 1) ? OP_REM_REAR : OP_REM_FRONT;
      case ($urandom_range(0, 7))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase
      issue_op(kind, value);
    end

    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/adeq_pkg.sv
rtl/core/adeq_ctrl.sv
rtl/core/adeq_dp.sv
rtl/core/array_double_ended_queue.sv
tb/sv/deque_checker.sv
tb/sv/tb.sv
